// ===== src/tssr_pkg.sv =====
// Package for the twinkling star square renderer.
// Shared widths, register decode codes and the grey RGB565 packing function.
// No dependencies.
package tssr_pkg;

	// APB decode: one 32-bit register, word address picked by paddr[2]
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic        REG_PERIOD = 1'b0;
	localparam logic [15:0] PERIOD_RST = 16'd4000;

	// signed screen coordinate: 16-bit center, minus half size, plus size
	localparam int unsigned COORD_W = 18;

	// shared restoring divider
	localparam int unsigned DIV_NUM_W = 32;
	localparam int unsigned DIV_DEN_W = 16;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [7:0] LEVEL_MAX = 8'hFF;

	typedef logic [15:0] color_t;

	// grey level into RGB565: 5 bits red, 6 bits green, 5 bits blue
	function automatic color_t grey565(input logic [7:0] lvl);
		grey565 = {lvl[7:3], lvl[7:2], lvl[7:3]};
	endfunction

endpackage

// ===== src/twinkling_star_square_renderer_unit.sv =====
// Twinkling star square renderer, top level.
// Depends on tssr_pkg (widths, register codes, RGB565 packing).
//
// Usage:
//  - Input channel (in_valid / in_stall): one request per star: center
//    star_x/star_y, side star_size, phase offset star_phase, frame_time.
//    A request is taken when in_valid is high and in_stall low.
//  - Output channel (out_valid / out_stall): one request per visible pixel
//    of the centered square, row by row, left to right. pixel_byte_offset
//    is (row*SCREEN_WIDTH+col)*2 in 16 bits, pixel_color is RGB565 grey,
//    last_pixel marks the final write of the star.
//  - APB port: register 0 (byte address 0) is star_period, 16 bits.
//  - Sequence: one shared 1-bit-per-cycle restoring divider runs twice
//    (time mod period, then ramp scaling), with setup state SETUP2 between
//    the divides and GEOM and OFFS after them before the first pixel; then
//    one pixel per cycle unless stalled. Stars that draw nothing (zero
//    size, period below two) are dropped at accept, offscreen stars after
//    the divides.
//  - in_stall stays high while a star is being worked; it drops as soon as
//    the last pixel sits in the output register, so the next star enters
//    while that pixel still waits.
//  - A stalled receiver freezes the output register and the pixel walk.
//  - Reset clears the sequencer and output valid; the period resets to 4000.
module twinkling_star_square_renderer_unit #(
	parameter int SCREEN_WIDTH  = 240,
	parameter int SCREEN_HEIGHT = 135,
	parameter int MAX_STAR_SIZE = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// star input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [15:0]                          star_x,
	input  logic [15:0]                          star_y,
	input  logic [3:0]                           star_size,
	input  logic [15:0]                          star_phase,
	input  logic [31:0]                          frame_time,
	// pixel output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [15:0]                          pixel_byte_offset,
	output logic [15:0]                          pixel_color,
	output logic                                 last_pixel,
	// APB configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tssr_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [tssr_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [tssr_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	localparam int XW = $clog2(SCREEN_WIDTH + 1);
	localparam int YW = $clog2(SCREEN_HEIGHT + 1);
	localparam int CW = tssr_pkg::COORD_W;
	localparam logic signed [CW-1:0] X_MAX = CW'(SCREEN_WIDTH - 1);
	localparam logic signed [CW-1:0] Y_MAX = CW'(SCREEN_HEIGHT - 1);
	localparam logic [3:0] SIDE_LIMIT = 4'(MAX_STAR_SIZE);
	localparam logic [15:0] ROW_STEP = 16'(2 * SCREEN_WIDTH);

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV1   = 3'd1;  // (time + phase) mod period
	localparam logic [2:0] ST_SETUP2 = 3'd2;  // fold triangle, scale by 255
	localparam logic [2:0] ST_DIV2   = 3'd3;  // ramp / half period
	localparam logic [2:0] ST_GEOM   = 3'd4;  // color, square bounds, clip
	localparam logic [2:0] ST_OFFS   = 3'd5;  // first byte offset
	localparam logic [2:0] ST_EMIT   = 3'd6;  // pixel walk

	localparam logic [tssr_pkg::DIV_CNT_W-1:0] DIV_LAST =
		tssr_pkg::DIV_CNT_W'(tssr_pkg::DIV_NUM_W - 1);

	logic [2:0] state_q;
	logic [15:0] period_q;

	// captured star
	logic [15:0] x_q, y_q;
	logic [3:0]  size_q;

	// shared divider
	logic [tssr_pkg::DIV_NUM_W-1:0] div_num_q;
	logic [tssr_pkg::DIV_DEN_W-1:0] div_den_q;
	logic [tssr_pkg::DIV_DEN_W-1:0] div_rem_q;
	logic [tssr_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// pixel walk
	logic [XW-1:0] px_q, x0c_q, x1c_q;
	logic [YW-1:0] py_q, y1c_q;
	logic [15:0]   cur_off_q, line_off_q;
	tssr_pkg::color_t color_q;

	// output register
	logic        out_valid_q;
	logic [15:0] off_out_q;
	logic [15:0] color_out_q;
	logic        last_out_q;

	// ---------------- configuration ----------------
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == tssr_pkg::REG_PERIOD);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == tssr_pkg::REG_PERIOD) ?
		{16'b0, period_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= tssr_pkg::PERIOD_RST;
		end else if (cfg_wr) begin
			period_q <= pwdata[15:0];
		end
	end

	// ---------------- input side ----------------
	logic       in_take;
	logic [3:0] size_clamp;
	logic       star_drop;
	assign in_stall   = (state_q != ST_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign size_clamp = (star_size > SIDE_LIMIT) ? SIDE_LIMIT : star_size;
	// nothing to draw: degenerate period or empty square
	assign star_drop  = (period_q < 16'd2) || (size_clamp == 4'd0);

	// ---------------- divider step ----------------
	// restoring division, one quotient bit per cycle, quotient shifts into
	// the dividend register from the bottom
	logic [16:0] div_shift, div_diff;
	logic        div_ge;
	logic [15:0] div_rem_nxt;
	logic [31:0] div_num_nxt;
	always_comb begin
		div_shift   = {div_rem_q, div_num_q[31]};
		div_diff    = div_shift - {1'b0, div_den_q};
		div_ge      = !div_diff[16];
		div_rem_nxt = div_ge ? div_diff[15:0] : div_shift[15:0];
		div_num_nxt = {div_num_q[30:0], div_ge};
	end

	// ---------------- triangle fold ----------------
	// p = remainder of the first divide; ramp numerator is p or period-p
	logic [14:0] half_per;
	logic [15:0] tri_num;
	logic [23:0] tri_scaled;
	always_comb begin
		half_per   = period_q[15:1];
		tri_num    = (div_rem_q < {1'b0, half_per}) ? div_rem_q : (period_q - div_rem_q);
		tri_scaled = {tri_num, 8'b0} - {8'b0, tri_num};  // * 255
	end

	// ---------------- square bounds ----------------
	logic signed [CW-1:0] x0, y0, x1, y1;
	logic                 off_screen;
	logic [XW-1:0]        x0c, x1c;
	logic [YW-1:0]        y0c, y1c;
	logic [7:0]           level;
	always_comb begin
		x0 = $signed({2'b00, x_q}) - $signed(CW'(size_q[3:1]));
		y0 = $signed({2'b00, y_q}) - $signed(CW'(size_q[3:1]));
		x1 = x0 + $signed(CW'(size_q)) - $signed(CW'(1));
		y1 = y0 + $signed(CW'(size_q)) - $signed(CW'(1));
		off_screen = (x0 > X_MAX) || (y0 > Y_MAX) || (x1 < 0) || (y1 < 0);
		x0c = (x0 < 0) ? '0 : XW'(x0);
		y0c = (y0 < 0) ? '0 : YW'(y0);
		x1c = (x1 > X_MAX) ? XW'(X_MAX) : XW'(x1);
		y1c = (y1 > Y_MAX) ? YW'(Y_MAX) : YW'(y1);
		// odd periods can overshoot the peak
		level = (|div_num_q[31:8]) ? tssr_pkg::LEVEL_MAX : div_num_q[7:0];
	end

	logic [31:0] first_base;
	assign first_base = 32'(py_q) * 32'(SCREEN_WIDTH) + 32'(px_q);

	// ---------------- output handshake ----------------
	logic out_free, emit_now, row_end, star_end;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_now = (state_q == ST_EMIT) && out_free;
	assign row_end  = (px_q == x1c_q);
	assign star_end = row_end && (py_q == y1c_q);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_take && !star_drop) state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_cnt_q == DIV_LAST) state_q <= ST_SETUP2;
				end
				ST_SETUP2: state_q <= ST_DIV2;
				ST_DIV2: begin
					if (div_cnt_q == DIV_LAST) state_q <= ST_GEOM;
				end
				ST_GEOM: state_q <= off_screen ? ST_IDLE : ST_OFFS;
				ST_OFFS: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_now && star_end) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q       <= star_x;
				y_q       <= star_y;
				size_q    <= size_clamp;
				div_num_q <= frame_time + {16'b0, star_phase};
				div_den_q <= period_q;
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV1, ST_DIV2: begin
				div_num_q <= div_num_nxt;
				div_rem_q <= div_rem_nxt;
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			ST_SETUP2: begin
				div_num_q <= {8'b0, tri_scaled};
				div_den_q <= {1'b0, half_per};
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			ST_GEOM: begin
				color_q <= tssr_pkg::grey565(level);
				px_q    <= x0c;
				x0c_q   <= x0c;
				x1c_q   <= x1c;
				py_q    <= y0c;
				y1c_q   <= y1c;
			end
			ST_OFFS: begin
				cur_off_q  <= {first_base[14:0], 1'b0};
				line_off_q <= {first_base[14:0], 1'b0};
			end
			ST_EMIT: begin
				if (emit_now && !star_end) begin
					if (row_end) begin
						px_q       <= x0c_q;
						py_q       <= py_q + 1'b1;
						line_off_q <= line_off_q + ROW_STEP;
						cur_off_q  <= line_off_q + ROW_STEP;
					end else begin
						px_q      <= px_q + 1'b1;
						cur_off_q <= cur_off_q + 16'd2;
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			off_out_q   <= cur_off_q;
			color_out_q <= color_q;
			last_out_q  <= star_end;
		end
	end

	assign out_valid         = out_valid_q;
	assign pixel_byte_offset = off_out_q;
	assign pixel_color       = color_out_q;
	assign last_pixel        = last_out_q;

`ifndef NO_ASSERTIONS
	a_div1_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1) && (div_cnt_q == DIV_LAST) |=> (state_q == ST_SETUP2))
		else $error("divider did not hand over after last step");

	a_div_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1) || (state_q == ST_DIV2) |-> (div_den_q != '0))
		else $error("divide by zero in shared divider");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (px_q <= x1c_q) && (py_q <= y1c_q) && (px_q >= x0c_q))
		else $error("pixel walk left the clipped square");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit_now && star_end |=> out_valid_q && last_out_q && (state_q != ST_EMIT))
		else $error("last pixel did not end the star");
`endif

endmodule

// ===== dv/tb_twinkling_star_square_renderer_unit.sv =====
// Testbench for twinkling_star_square_renderer_unit: directed and random stars under
// several star periods, pixel writes checked against an in-bench predictor.
// Depends on tssr_pkg and the renderer top level.
`timescale 1ns / 100ps

module tb_twinkling_star_square_renderer_unit;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 11;
	localparam int SCR_W         = 240;
	localparam int SCR_H         = 135;
	localparam int MAX_SIDE      = 8;
	// two divides plus setup, with margin, for stars that write nothing
	localparam int SETTLE_CYCLES = 150;
	localparam int LONG_HOLD     = 400;
	localparam int TIMEOUT_NS    = 10_000_000;

	// register map: star_period is register 0, byte address 0
	localparam logic [tssr_pkg::APB_ADDR_W-1:0] STAR_PERIOD_ADDR = '0;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [3:0]  size;
		logic [15:0] phase;
		logic [31:0] frame_ms;
	} star_req_t;

	typedef struct packed {
		logic [15:0]      offset;
		tssr_pkg::color_t color;
		logic             is_last;
	} pixel_write_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [15:0] star_x     = '0;
	logic [15:0] star_y     = '0;
	logic [3:0]  star_size  = '0;
	logic [15:0] star_phase = '0;
	logic [31:0] frame_time = '0;

	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [15:0] pixel_byte_offset;
	logic [15:0] pixel_color;
	logic        last_pixel;

	logic                               psel    = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite  = 1'b0;
	logic [tssr_pkg::APB_ADDR_W-1:0]    paddr   = '0;
	logic [tssr_pkg::APB_DATA_W-1:0]    pwdata  = '0;
	logic [tssr_pkg::APB_DATA_W-1:0]    prdata;
	logic                               pready;

	// stars waiting to be offered, and pixel writes the predictor says are due
	star_req_t    stars_pending[$];
	pixel_write_t pixel_writes_due[$];

	// predictor's copy of the period register
	logic [15:0] period_cfg = tssr_pkg::PERIOD_RST;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_asked    = 0;
	int unsigned hold_given    = 0;
	int unsigned hold_left     = 0;

	int unsigned errors         = 0;
	int unsigned stars_taken    = 0;
	int unsigned pixels_checked = 0;
	int unsigned period_writes  = 0;

	// set at each rising edge when the offered star went in
	logic      star_taken = 1'b0;
	star_req_t next_star;

	twinkling_star_square_renderer_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.star_x           (star_x),
		.star_y           (star_y),
		.star_size        (star_size),
		.star_phase       (star_phase),
		.frame_time       (frame_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pixel_byte_offset(pixel_byte_offset),
		.pixel_color      (pixel_color),
		.last_pixel       (last_pixel),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Expected pixel writes for one star: triangle brightness over the period,
	// grey RGB565, square clipped to the screen, row-major order.
	function automatic void predict_star(input star_req_t r);
		int               side, x0, y0, x1, y1, off_full;
		logic [31:0]      period32, ph_sum, p, half, ramp, lvl;
		logic [7:0]       a;
		tssr_pkg::color_t grey;
		pixel_write_t     w;
		// period below two: nothing drawn
		if (period_cfg < 16'd2)
			return;
		side = (r.size > MAX_SIDE) ? MAX_SIDE : int'(r.size);
		if (side == 0)
			return;
		period32 = {16'h0, period_cfg};
		ph_sum   = r.frame_ms + {16'h0, r.phase};   // wraps at 2^32
		p        = ph_sum % period32;
		half     = period32 >> 1;
		ramp     = (p < half) ? p : (period32 - p);
		lvl      = (ramp * 32'd255) / half;
		// odd periods can overshoot the peak
		a        = (lvl > 32'd255) ? 8'hFF : lvl[7:0];
		grey     = (16'(a >> 3) << 11) | (16'(a >> 2) << 5) | 16'(a >> 3);
		x0 = int'(r.x) - side / 2;
		y0 = int'(r.y) - side / 2;
		x1 = x0 + side - 1;
		y1 = y0 + side - 1;
		if (x0 > SCR_W - 1 || y0 > SCR_H - 1 || x1 < 0 || y1 < 0)
			return;
		if (x0 < 0) x0 = 0;
		if (y0 < 0) y0 = 0;
		if (x1 > SCR_W - 1) x1 = SCR_W - 1;
		if (y1 > SCR_H - 1) y1 = SCR_H - 1;
		for (int py = y0; py <= y1; py++) begin
			for (int px = x0; px <= x1; px++) begin
				off_full  = (py * SCR_W + px) * 2;
				w.offset  = off_full[15:0];
				w.color   = grey;
				w.is_last = (py == y1 && px == x1);
				pixel_writes_due.push_back(w);
			end
		end
	endfunction

	// Mostly stars near the screen with small sides; some anywhere in the
	// 16-bit plane, and some zero or oversized sides.
	function automatic star_req_t random_star();
		star_req_t   r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 75) begin
			r.x = 16'($urandom_range(SCR_W + 7));
			r.y = 16'($urandom_range(SCR_H + 7));
		end else begin
			r.x = 16'($urandom);
			r.y = 16'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 78)
			r.size = 4'($urandom_range(1, 4));
		else if (pick < 92)
			r.size = 4'($urandom_range(5, MAX_SIDE));
		else
			r.size = 4'($urandom_range(0, 15));
		r.phase    = 16'($urandom);
		r.frame_ms = $urandom;
		return r;
	endfunction

	task automatic push_star(input int x, input int y, input int size,
	                         input int phase, input logic [31:0] frame_ms);
		star_req_t r;
		r.x        = 16'(x);
		r.y        = 16'(y);
		r.size     = 4'(size);
		r.phase    = 16'(phase);
		r.frame_ms = frame_ms;
		stars_pending.push_back(r);
	endtask

	task automatic push_random(input int count);
		repeat (count) stars_pending.push_back(random_star());
	endtask

	// Wait until every star is in, every due write has come out, then give
	// a star that draws nothing time to leave the divider.
	task automatic drain_and_settle();
		while (stars_pending.size() != 0 || in_valid)
			@(posedge clk);
		while (pixel_writes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of star_period, then a read back in the next transfer.
	task automatic write_star_period(input logic [15:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= STAR_PERIOD_ADDR;
		pwdata  <= {16'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		period_cfg = value;
		period_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== value) begin
			errors++;
			$display("%0t: star_period read back: expected %h, got %h",
			         $time, value, prdata[15:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Star driver: a new star only once the one on the port has gone in;
	// random gaps between stars, never a change while stalled.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || star_taken) begin
			if (stars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_star   = stars_pending.pop_front();
				in_valid   <= 1'b1;
				star_x     <= next_star.x;
				star_y     <= next_star.y;
				star_size  <= next_star.size;
				star_phase <= next_star.phase;
				frame_time <= next_star.frame_ms;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Pixel receiver: random stalls, plus a long hold-off on request so that
	// the renderer backs up and holds its input stalled.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_asked != hold_given) begin
			hold_given++;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Predict on each accepted star, check each accepted pixel write.
	always @(posedge clk) begin
		pixel_write_t due;
		if (arst_n && in_valid && !in_stall) begin
			stars_taken++;
			predict_star({star_x, star_y, star_size, star_phase, frame_time});
		end
		if (arst_n && out_valid && !out_stall) begin
			pixels_checked++;
			if (pixel_writes_due.size() == 0) begin
				errors++;
				$display("%0t: pixel write with none due: off=%h color=%h last=%b",
				         $time, pixel_byte_offset, pixel_color, last_pixel);
			end else begin
				due = pixel_writes_due.pop_front();
				if (pixel_byte_offset !== due.offset || pixel_color !== due.color ||
				    last_pixel !== due.is_last) begin
					errors++;
					$display("%0t: pixel write: expected off=%h color=%h last=%b, got off=%h color=%h last=%b",
					         $time, due.offset, due.color, due.is_last,
					         pixel_byte_offset, pixel_color, last_pixel);
				end
			end
		end
		star_taken <= arst_n && in_valid && !in_stall;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles a quarter of the time, receiver most of it
		send_idle_pct = 25;
		recv_idle_pct = 65;

		// Reset period 4000 (half 2000): corners, edges, clipping, sizes.
		push_star(0, 0, 8, 0, 32'd0);                 // top-left, clipped, dark
		push_star(239, 134, 8, 0, 32'd2000);          // bottom-right, clipped, peak
		push_star(0, 0, 1, 0, 32'd1000);              // first byte offset
		push_star(239, 134, 1, 0, 32'd3000);          // last byte offset
		push_star(120, 67, 2, 100, 32'd400);
		push_star(120, 67, 3, 0, 32'd1999);
		push_star(120, 67, 4, 0, 32'd2001);
		push_star(120, 67, 5, 0, 32'd3999);
		push_star(120, 67, 6, 0, 32'd4000);
		push_star(120, 67, 7, 65535, 32'd12345);
		push_star(60, 30, 0, 0, 32'd1000);            // zero size
		push_star(60, 30, 9, 0, 32'd500);             // oversized, drawn as 8
		push_star(60, 30, 15, 1, 32'd1500);
		push_star(65535, 65535, 8, 0, 32'd0);         // far offscreen
		push_star(244, 10, 8, 0, 32'd800);            // just right of screen
		push_star(243, 10, 8, 0, 32'd800);            // one column visible
		push_star(10, 139, 8, 0, 32'd800);            // just below screen
		push_star(10, 138, 8, 0, 32'd800);            // one row visible
		push_star(3, 3, 8, 0, 32'd900);               // left/top clip by one
		push_star(200, 100, 4, 65535, 32'hFFFF_FFFF); // sum wraps 2^32
		push_star(200, 100, 4, 0, 32'hFFFF_FFFF);
		drain_and_settle();

		// Period 3: half is 1, so the ramp overshoots and must saturate.
		write_star_period(16'd3);
		push_star(100, 50, 2, 0, 32'd1);              // overshoot, saturates
		push_star(100, 50, 2, 0, 32'd0);
		push_star(100, 50, 2, 0, 32'd2);
		push_random(50);
		drain_and_settle();

		write_star_period(16'd2);                     // smallest working period
		push_random(40);
		drain_and_settle();

		// receiver idles a quarter, sender most of the time
		send_idle_pct = 65;
		recv_idle_pct = 25;

		write_star_period(16'hFFFF);
		hold_asked++;
		push_random(60);
		drain_and_settle();

		// periods below two draw nothing at all
		write_star_period(16'd0);
		push_random(15);
		drain_and_settle();
		write_star_period(16'd1);
		push_random(15);
		drain_and_settle();

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;

		write_star_period(16'($urandom_range(2, 65535)));
		hold_asked++;
		push_random(80);
		drain_and_settle();

		write_star_period(16'($urandom_range(2, 20)));
		push_random(80);
		drain_and_settle();

		write_star_period(tssr_pkg::PERIOD_RST);
		push_random(50);
		drain_and_settle();

		foreach (pixel_writes_due[i]) begin
			errors++;
			$display("%0t: pixel write never came: off=%h color=%h last=%b", $time,
			         pixel_writes_due[i].offset, pixel_writes_due[i].color,
			         pixel_writes_due[i].is_last);
		end

		$display("Rendered %0d stars under %0d period settings, %0d pixel writes checked,",
		         stars_taken, period_writes + 1, pixels_checked);
		$display("with random gaps on both sides and %0d long output hold-offs.", hold_given);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
